// File: design/utlsc_pkg.sv
// Shared types, constants and leap-second tables for the UTC/TAI converter.
// Used by utlsc_leap_lookup, utlsc_const_div and the top level; no dependencies.
`default_nettype none

package utlsc_pkg;

   // Field and datapath widths
   localparam int TIME_W   = 64;            // time_ns and converted_ns
   localparam int WIDE_W   = TIME_W + 1;    // time with one guard bit
   localparam int NUM_W    = TIME_W + 2;    // drift numerator, signed
   localparam int QUOT_W   = 39;            // drift quotient magnitude
   localparam int SQUOT_W  = QUOT_W + 1;    // signed drift quotient
   localparam int DIVISOR_W = 27;

   // Leap-second table
   localparam int STORED_ENTRIES       = 24;
   localparam int LEAP_ENTRIES_DEFAULT = 24;
   localparam int DAY_W = 14;
   localparam int SEC_W = 6;

   localparam logic [DAY_W-1:0] LEAP_DAY [STORED_ENTRIES] = '{
      14'd730,  14'd912,  14'd1096, 14'd1461, 14'd1826, 14'd2191, 14'd2557, 14'd2922,
      14'd3287, 14'd3652, 14'd4199, 14'd4564, 14'd4929, 14'd5660, 14'd6574, 14'd7305,
      14'd7670, 14'd8217, 14'd8582, 14'd8947, 14'd9496, 14'd10043, 14'd10592, 14'd13149
   };
   localparam logic [SEC_W-1:0] LEAP_SEC [STORED_ENTRIES] = '{
      6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33
   };

   localparam logic signed [TIME_W-1:0] NS_PER_DAY  = 64'sd86400000000000;
   localparam logic signed [TIME_W-1:0] NS_PER_SEC  = 64'sd1000000000;
   localparam logic signed [TIME_W-1:0] DRIFT_CONST = 64'sd8000082000;
   localparam logic signed [TIME_W-1:0] TIME_MAX    = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [TIME_W-1:0] TIME_MIN    = 64'sh8000_0000_0000_0000;

   // Drift numerators: UTC to TAI uses 3t + C*10^8, TAI to UTC uses 3(t - C)
   localparam logic signed [NUM_W-1:0] DRIFT_BIAS_UTC = 66'sd800008200000000000;
   localparam logic signed [NUM_W-1:0] DRIFT_BIAS_TAI = -66'sd24000246000;

   // Divisors and their reciprocals scaled by 2^RECIP_SHIFT (rounded down)
   localparam logic [DIVISOR_W-1:0] DIV_UTC = 27'd100000000;
   localparam logic [DIVISOR_W-1:0] DIV_TAI = 27'd99999997;
   localparam int RECIP_SHIFT = 65;
   localparam logic [127:0] RECIP_UTC_FULL = (128'd1 << RECIP_SHIFT) / 128'd100000000;
   localparam logic [127:0] RECIP_TAI_FULL = (128'd1 << RECIP_SHIFT) / 128'd99999997;
   localparam logic [QUOT_W-1:0] RECIP_UTC = RECIP_UTC_FULL[QUOT_W-1:0];
   localparam logic [QUOT_W-1:0] RECIP_TAI = RECIP_TAI_FULL[QUOT_W-1:0];

   // Partial-product split of the reciprocal multiply
   localparam int LO_W      = 32;
   localparam int MAG_HI_W  = WIDE_W - LO_W;
   localparam int RCP_HI_W  = QUOT_W - LO_W;
   localparam int PROD_W    = WIDE_W + QUOT_W;

   // Register stages inside the divider
   localparam int DIV_LATENCY = 4;

   typedef enum logic {
      FUNC_UTC_TO_TAI = 1'b0,
      FUNC_TAI_TO_UTC = 1'b1
   } func_type;

   // Per-request data carried alongside the divider
   typedef struct packed {
      func_type                    func;
      logic                        pre;
      logic signed [TIME_W-1:0]    tab_res;
      logic signed [WIDE_W-1:0]    base;
   } side_type;

endpackage

`default_nettype wire

// File: design/utlsc_leap_lookup.sv
// Leap-second table compare: finds the offset interval and the table result.
// Depends on utlsc_pkg; purely combinational.
`default_nettype none

module utlsc_leap_lookup #(
   parameter int LEAP_ENTRIES = utlsc_pkg::LEAP_ENTRIES_DEFAULT
) (
   input  utlsc_pkg::func_type                      func,
   input  logic signed [utlsc_pkg::TIME_W-1:0]      time_ns,
   output logic                                     pre_table,
   output logic signed [utlsc_pkg::TIME_W-1:0]      table_ns
);

   localparam int USED = (LEAP_ENTRIES > utlsc_pkg::STORED_ENTRIES) ?
                         utlsc_pkg::STORED_ENTRIES :
                         ((LEAP_ENTRIES < 1) ? 1 : LEAP_ENTRIES);

   logic signed [utlsc_pkg::TIME_W-1:0] sec_ns  [USED];
   logic signed [utlsc_pkg::TIME_W-1:0] thr_utc [USED];
   logic signed [utlsc_pkg::TIME_W-1:0] thr_tai [USED];
   logic [USED-1:0]                     reached;
   logic signed [utlsc_pkg::TIME_W-1:0] sel_sec;
   logic signed [utlsc_pkg::WIDE_W-1:0] sum;

   // Constant thresholds; TAI thresholds are shifted by the entry's own offset
   for (genvar g = 0; g < USED; g++) begin : g_thr
      assign sec_ns[g]  = $signed({{(utlsc_pkg::TIME_W-utlsc_pkg::SEC_W){1'b0}},
                                   utlsc_pkg::LEAP_SEC[g]}) * utlsc_pkg::NS_PER_SEC;
      assign thr_utc[g] = $signed({{(utlsc_pkg::TIME_W-utlsc_pkg::DAY_W){1'b0}},
                                   utlsc_pkg::LEAP_DAY[g]}) * utlsc_pkg::NS_PER_DAY;
      assign thr_tai[g] = thr_utc[g] + sec_ns[g];
      assign reached[g] = (func == utlsc_pkg::FUNC_TAI_TO_UTC) ?
                          (time_ns >= thr_tai[g]) : (time_ns >= thr_utc[g]);
   end

   assign pre_table = ~reached[0];

   // The last threshold reached selects the offset
   always_comb begin
      sel_sec = sec_ns[0];
      for (int i = 1; i < USED; i++) begin
         if (reached[i]) begin
            sel_sec = sec_ns[i];
         end
      end
   end

   // Apply the offset and saturate at the 64-bit limits
   always_comb begin
      if (func == utlsc_pkg::FUNC_TAI_TO_UTC) begin
         sum = {time_ns[utlsc_pkg::TIME_W-1], time_ns} + {1'b0, sel_sec};
      end else begin
         sum = {time_ns[utlsc_pkg::TIME_W-1], time_ns} - {1'b0, sel_sec};
      end
      if (sum[utlsc_pkg::WIDE_W-1] != sum[utlsc_pkg::TIME_W-1]) begin
         table_ns = sum[utlsc_pkg::WIDE_W-1] ? utlsc_pkg::TIME_MIN : utlsc_pkg::TIME_MAX;
      end else begin
         table_ns = sum[utlsc_pkg::TIME_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: design/utlsc_const_div.sv
// Four-stage pipelined division of a signed magnitude by one of two constants,
// truncating toward zero, via reciprocal multiply and one correction step.
// Depends on utlsc_pkg.
`default_nettype none

module utlsc_const_div (
   input  logic                                  clock,
   input  logic                                  enable,
   input  utlsc_pkg::func_type                   func,
   input  logic                                  negative,
   input  logic [utlsc_pkg::WIDE_W-1:0]          magnitude,
   output logic signed [utlsc_pkg::SQUOT_W-1:0]  quotient
);

   localparam int LO_W  = utlsc_pkg::LO_W;
   localparam int REM_W = utlsc_pkg::WIDE_W + 1;

   logic [utlsc_pkg::QUOT_W-1:0]    recip;
   logic [utlsc_pkg::DIVISOR_W-1:0] divisor;

   // Stage 1: partial products
   logic [2*LO_W-1:0]                                   p_ll_in, p_ll_ff;
   logic [LO_W+utlsc_pkg::RCP_HI_W-1:0]                 p_lh_in, p_lh_ff;
   logic [utlsc_pkg::MAG_HI_W+LO_W-1:0]                 p_hl_in, p_hl_ff;
   logic [utlsc_pkg::MAG_HI_W+utlsc_pkg::RCP_HI_W-1:0]  p_hh_in, p_hh_ff;
   logic [utlsc_pkg::WIDE_W-1:0]                        mag1_ff, mag2_ff, mag3_ff;
   logic [utlsc_pkg::DIVISOR_W-1:0]                     div1_ff, div2_ff, div3_ff;
   logic                                                neg1_ff, neg2_ff, neg3_ff;

   // Stage 2: quotient estimate, stage 3: estimate times divisor
   logic [utlsc_pkg::PROD_W-1:0]  full_prod;
   logic [utlsc_pkg::QUOT_W-1:0]  q0_in, q0_ff, q0_3_ff;
   logic [REM_W-1:0]              qd_in, qd_ff;

   // Stage 4: correction and sign
   logic [REM_W-1:0]                     rem;
   logic [utlsc_pkg::SQUOT_W-1:0]        q_fix;
   logic signed [utlsc_pkg::SQUOT_W-1:0] quotient_in, quotient_ff;

   // Constant selection by direction
   always_comb begin
      unique case (func)
         utlsc_pkg::FUNC_UTC_TO_TAI: begin
            recip   = utlsc_pkg::RECIP_UTC;
            divisor = utlsc_pkg::DIV_UTC;
         end
         utlsc_pkg::FUNC_TAI_TO_UTC: begin
            recip   = utlsc_pkg::RECIP_TAI;
            divisor = utlsc_pkg::DIV_TAI;
         end
         default: begin
            recip   = utlsc_pkg::RECIP_UTC;
            divisor = utlsc_pkg::DIV_UTC;
         end
      endcase
   end

   // Four partial products of magnitude times reciprocal
   assign p_ll_in = (2*LO_W)'(magnitude[LO_W-1:0]) * (2*LO_W)'(recip[LO_W-1:0]);
   assign p_lh_in = (LO_W+utlsc_pkg::RCP_HI_W)'(magnitude[LO_W-1:0])
                  * (LO_W+utlsc_pkg::RCP_HI_W)'(recip[utlsc_pkg::QUOT_W-1:LO_W]);
   assign p_hl_in = (utlsc_pkg::MAG_HI_W+LO_W)'(magnitude[utlsc_pkg::WIDE_W-1:LO_W])
                  * (utlsc_pkg::MAG_HI_W+LO_W)'(recip[LO_W-1:0]);
   assign p_hh_in = (utlsc_pkg::MAG_HI_W+utlsc_pkg::RCP_HI_W)'
                       (magnitude[utlsc_pkg::WIDE_W-1:LO_W])
                  * (utlsc_pkg::MAG_HI_W+utlsc_pkg::RCP_HI_W)'
                       (recip[utlsc_pkg::QUOT_W-1:LO_W]);

   // Sum the partial products; the estimate is low by at most one
   assign full_prod = (utlsc_pkg::PROD_W'(p_hh_ff) << (2*LO_W))
                    + (utlsc_pkg::PROD_W'(p_hl_ff) << LO_W)
                    + (utlsc_pkg::PROD_W'(p_lh_ff) << LO_W)
                    + utlsc_pkg::PROD_W'(p_ll_ff);
   assign q0_in = full_prod[utlsc_pkg::PROD_W-1:utlsc_pkg::RECIP_SHIFT];

   assign qd_in = REM_W'(q0_ff) * REM_W'(div2_ff);

   // Remainder stays below twice the divisor, so one step corrects it
   always_comb begin
      rem   = REM_W'(mag3_ff) - qd_ff;
      q_fix = utlsc_pkg::SQUOT_W'(q0_3_ff)
            + ((rem >= REM_W'(div3_ff)) ? utlsc_pkg::SQUOT_W'(1) : utlsc_pkg::SQUOT_W'(0));
      quotient_in = neg3_ff ? -$signed(q_fix) : $signed(q_fix);
   end

   // Pipeline registers, held while the output side stalls
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ll_ff     <= p_ll_in;
         p_lh_ff     <= p_lh_in;
         p_hl_ff     <= p_hl_in;
         p_hh_ff     <= p_hh_in;
         mag1_ff     <= magnitude;
         div1_ff     <= divisor;
         neg1_ff     <= negative;
         q0_ff       <= q0_in;
         mag2_ff     <= mag1_ff;
         div2_ff     <= div1_ff;
         neg2_ff     <= neg1_ff;
         qd_ff       <= qd_in;
         q0_3_ff     <= q0_ff;
         mag3_ff     <= mag2_ff;
         div3_ff     <= div2_ff;
         neg3_ff     <= neg2_ff;
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

`default_nettype wire

// File: design/utc_tai_leap_second_converter.sv
// Top level of the UTC/TAI leap-second converter: handshakes and pipeline.
// Depends on utlsc_pkg, utlsc_leap_lookup and utlsc_const_div.
//
//   Channel   Dir   tdata (low bit up)          tuser
//   req_      in    [63:0] time_ns (signed)     [0] func (0 UTC to TAI, 1 TAI to UTC)
//   rsp_      out   [63:0] converted_ns         [0] pre_table
//
// One request is taken per cycle while the response side does not stall; its response
// passes through seven register stages: input register, table and numerator stage, four
// divider stages, output register. The depth is set by the reciprocal multiply of the
// pre-1972 drift division.
// A stalled response holds the whole pipeline, so req_tready follows rsp_tready
// whenever the output register is full. Reset clears only the valid bits.
`default_nettype none

module utc_tai_leap_second_converter #(
   parameter int LEAP_ENTRIES = utlsc_pkg::LEAP_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] time_ns
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] converted_ns
   output logic [0:0]  rsp_tuser    // [0] pre_table
);

   localparam int TIME_W = utlsc_pkg::TIME_W;
   localparam int WIDE_W = utlsc_pkg::WIDE_W;
   localparam int NUM_W  = utlsc_pkg::NUM_W;
   localparam int LAT    = utlsc_pkg::DIV_LATENCY;

   logic advance;

   // Input register
   logic                      in_valid_ff;
   utlsc_pkg::func_type       in_func_ff;
   logic signed [TIME_W-1:0]  in_time_ff;

   // Table and numerator stage
   logic                      look_pre;
   logic signed [TIME_W-1:0]  look_ns;
   logic signed [NUM_W-1:0]   t_ext;
   logic signed [NUM_W-1:0]   num;
   logic [WIDE_W-1:0]         mag_in;
   utlsc_pkg::side_type       side_in;
   logic                      s1_valid_ff;
   utlsc_pkg::side_type       s1_side_ff;
   logic                      s1_neg_ff;
   logic [WIDE_W-1:0]         s1_mag_ff;

   // Side data alongside the divider
   logic                      valid_pipe_ff [LAT];
   utlsc_pkg::side_type       side_pipe_ff  [LAT];
   logic signed [utlsc_pkg::SQUOT_W-1:0] quotient;

   // Output register
   utlsc_pkg::side_type       last_side;
   logic signed [NUM_W-1:0]   drift_sum;
   logic signed [TIME_W-1:0]  result_in;
   logic                      rsp_valid_ff;
   logic signed [TIME_W-1:0]  rsp_data_ff;
   logic                      rsp_pre_ff;

   // The pipeline moves whenever the output register is free or being emptied
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance;

   utlsc_leap_lookup #(
      .LEAP_ENTRIES (LEAP_ENTRIES)
   ) u_lookup (
      .func      (in_func_ff),
      .time_ns   (in_time_ff),
      .pre_table (look_pre),
      .table_ns  (look_ns)
   );

   // Drift numerator and base term for the divider
   always_comb begin
      t_ext = {{(NUM_W-TIME_W){in_time_ff[TIME_W-1]}}, in_time_ff};
      side_in.func    = in_func_ff;
      side_in.pre     = look_pre;
      side_in.tab_res = look_ns;
      if (in_func_ff == utlsc_pkg::FUNC_TAI_TO_UTC) begin
         num = (t_ext <<< 1) + t_ext + utlsc_pkg::DRIFT_BIAS_TAI;
         side_in.base = {in_time_ff[TIME_W-1], in_time_ff}
                      - {utlsc_pkg::DRIFT_CONST[TIME_W-1], utlsc_pkg::DRIFT_CONST};
      end else begin
         num = (t_ext <<< 1) + t_ext + utlsc_pkg::DRIFT_BIAS_UTC;
         side_in.base = {in_time_ff[TIME_W-1], in_time_ff};
      end
      mag_in = num[NUM_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
   end

   utlsc_const_div u_div (
      .clock     (clock),
      .enable    (advance),
      .func      (s1_side_ff.func),
      .negative  (s1_neg_ff),
      .magnitude (s1_mag_ff),
      .quotient  (quotient)
   );

   // Drift: base minus (UTC to TAI) or plus quotient, saturated; else table value
   always_comb begin
      last_side = side_pipe_ff[LAT-1];
      if (last_side.func == utlsc_pkg::FUNC_TAI_TO_UTC) begin
         drift_sum = NUM_W'(last_side.base) + NUM_W'(quotient);
      end else begin
         drift_sum = NUM_W'(last_side.base) - NUM_W'(quotient);
      end
      if (last_side.pre) begin
         if (drift_sum[NUM_W-1:TIME_W-1] == '0 || drift_sum[NUM_W-1:TIME_W-1] == '1) begin
            result_in = drift_sum[TIME_W-1:0];
         end else begin
            result_in = drift_sum[NUM_W-1] ? utlsc_pkg::TIME_MIN : utlsc_pkg::TIME_MAX;
         end
      end else begin
         result_in = last_side.tab_res;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LAT; i++) begin
            valid_pipe_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         in_valid_ff      <= req_tvalid;
         s1_valid_ff      <= in_valid_ff;
         valid_pipe_ff[0] <= s1_valid_ff;
         for (int i = 1; i < LAT; i++) begin
            valid_pipe_ff[i] <= valid_pipe_ff[i-1];
         end
         rsp_valid_ff <= valid_pipe_ff[LAT-1];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         in_func_ff      <= utlsc_pkg::func_type'(req_tuser[0]);
         in_time_ff      <= req_tdata;
         s1_side_ff      <= side_in;
         s1_neg_ff       <= num[NUM_W-1];
         s1_mag_ff       <= mag_in;
         side_pipe_ff[0] <= s1_side_ff;
         for (int i = 1; i < LAT; i++) begin
            side_pipe_ff[i] <= side_pipe_ff[i-1];
         end
         rsp_data_ff <= result_in;
         rsp_pre_ff  <= last_side.pre;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_pre_ff;

endmodule

`default_nettype wire

// File: dv/utc_tai_leap_second_converter_tb.sv
// Self-checking testbench for the UTC/TAI leap-second converter: a queue-fed stream
// driver, a response monitor and an in-bench predictor of the conversion.
// Depends on utlsc_pkg (func_type) and utc_tai_leap_second_converter.
`default_nettype none

module utc_tai_leap_second_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Conversion constants and limits
   localparam int     ENTRIES      = 24;
   localparam longint NS_DAY       = 64'sd86400000000000;
   localparam longint NS_SEC       = 64'sd1000000000;
   localparam longint DRIFT_OFFSET = 64'sd8000082000;
   localparam longint DRIFT_SCALE  = 64'sd100000000;
   localparam longint DRIFT_INV    = 64'sd99999997;
   localparam longint T_MAX        = 64'sh7fff_ffff_ffff_ffff;
   localparam longint T_MIN        = 64'sh8000_0000_0000_0000;
   localparam int     PHASES       = 4;
   localparam int     PHASE_ITEMS  = 488;
   localparam int     DRAIN_CYCLES = 20;
   localparam int     CYCLE_LIMIT  = 200000;

   typedef struct {
      utlsc_pkg::func_type func;
      longint              time_ns;
      int                  phase;
   } request_type;

   typedef struct {
      longint converted;
      logic   pre;
   } conversion_type;

   // Leap dates in days since 1970 and the offset in seconds from each date on
   int leap_days [ENTRIES] = '{
      730, 912, 1096, 1461, 1826, 2191, 2557, 2922,
      3287, 3652, 4199, 4564, 4929, 5660, 6574, 7305,
      7670, 8217, 8582, 8947, 9496, 10043, 10592, 13149
   };
   int leap_offsets [ENTRIES] = '{
      10, 11, 12, 13, 14, 15, 16, 17,
      18, 19, 20, 21, 22, 23, 24, 25,
      26, 27, 28, 29, 30, 31, 32, 33
   };

   // Idle percentages per phase: none, sender, receiver, both
   int send_idle_pct [PHASES] = '{0, 50, 0, 28};
   int recv_stall_pct [PHASES] = '{0, 0, 50, 28};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;     // [63:0] time_ns
   logic [0:0]  req_tuser = '0;     // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [63:0] converted_ns
   logic [0:0]  rsp_tuser;          // [0] pre_table

   request_type    request_queue [$];
   conversion_type expected_conversions [$];
   conversion_type due;
   int             active_phase = 0;
   int             error_count = 0;
   int             cycle_count = 0;

   utc_tai_leap_second_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Signed addition clamped to the 64-bit limits.
   function automatic longint add_clamped(longint a, longint b);
      if (b > 0 && a > T_MAX - b) return T_MAX;
      if (b < 0 && a < T_MIN - b) return T_MIN;
      return a + b;
   endfunction

   // Start of table interval i in the source scale: TAI thresholds are shifted
   // by the entry's own offset.
   function automatic longint threshold_ns(utlsc_pkg::func_type f, int i);
      longint thr;
      thr = longint'(leap_days[i]) * NS_DAY;
      if (f == utlsc_pkg::FUNC_TAI_TO_UTC) thr = thr + longint'(leap_offsets[i]) * NS_SEC;
      return thr;
   endfunction

   // Expected response for one request.
   function automatic conversion_type convert_time(utlsc_pkg::func_type f, longint t);
      conversion_type c;
      int     slot;
      longint q, r, r3, total, rm, x;
      slot  = ENTRIES - 1;
      c.pre = 1'b0;
      if (t < threshold_ns(f, 0)) begin
         c.pre = 1'b1;
      end else begin
         for (int i = 1; i < ENTRIES; i++) begin
            if (t < threshold_ns(f, i)) begin
               slot = i - 1;
               break;
            end
         end
      end

      if (f == utlsc_pkg::FUNC_UTC_TO_TAI) begin
         if (c.pre) begin
            // Offset is 3t/10^8 + C truncated toward zero, computed without overflow
            q     = t / DRIFT_SCALE;
            r     = t % DRIFT_SCALE;
            r3    = 3 * r;
            total = 3 * q + DRIFT_OFFSET + r3 / DRIFT_SCALE;
            rm    = r3 % DRIFT_SCALE;
            if (rm < 0 && total > 0) total = total - 1;
            else if (rm > 0 && total < 0) total = total + 1;
            c.converted = add_clamped(t, -total);
         end else begin
            c.converted = add_clamped(t, -(longint'(leap_offsets[slot]) * NS_SEC));
         end
      end else begin
         if (c.pre) begin
            // (t - C) * 10^8 / 99999997, truncated toward zero
            if (t < T_MIN + DRIFT_OFFSET) begin
               c.converted = T_MIN;
            end else begin
               x = t - DRIFT_OFFSET;
               q = x / DRIFT_INV;
               r = x % DRIFT_INV;
               c.converted = add_clamped(x, 3 * q + (3 * r) / DRIFT_INV);
            end
         end else begin
            c.converted = add_clamped(t, longint'(leap_offsets[slot]) * NS_SEC);
         end
      end
      return c;
   endfunction

   // Random time biased towards table edges, the drift era and the extremes.
   function automatic longint random_time(utlsc_pkg::func_type f);
      int     pick;
      int     i;
      longint t;
      pick = $urandom_range(0, 99);
      i    = $urandom_range(0, ENTRIES - 1);
      if (pick < 30) begin
         t = {$urandom, $urandom};
      end else if (pick < 50) begin
         t = threshold_ns(f, i) + longint'($urandom_range(0, 2000)) - 1000;
      end else if (pick < 65) begin
         // Wide spread across a leap date, including the shifted TAI window
         t = longint'(leap_days[i]) * NS_DAY
             + longint'($urandom_range(0, 100000)) * 1000000 - 64'sd50000000000;
      end else if (pick < 80) begin
         t = $signed({$urandom, $urandom}) >>> $urandom_range(8, 40);
      end else if (pick < 90) begin
         if ($urandom_range(0, 1) == 1)
            t = T_MAX - (longint'($urandom) << $urandom_range(0, 5));
         else
            t = T_MIN + (longint'($urandom) << $urandom_range(0, 5));
      end else begin
         t = longint'($urandom_range(0, 20000)) * NS_DAY
             + longint'($urandom) * longint'($urandom_range(1, 20000));
      end
      return t;
   endfunction

   function automatic void add_request(utlsc_pkg::func_type f, longint t, int phase);
      request_type item;
      item.func    = f;
      item.time_ns = t;
      item.phase   = phase;
      request_queue.push_back(item);
   endfunction

   // Driver: presents the head of the queue and records the expectation on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_conversions.push_back(
               convert_time(utlsc_pkg::func_type'(req_tuser[0]), req_tdata));
            void'(request_queue.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct[request_queue[0].phase]) begin
               req_tvalid   <= 1'b1;
               req_tdata    <= request_queue[0].time_ns;
               req_tuser[0] <= request_queue[0].func;
               active_phase <= request_queue[0].phase;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_conversions.size() == 0) begin
               $error("unexpected response: converted_ns %0d, pre_table %0d",
                      $signed(rsp_tdata), rsp_tuser[0]);
               error_count++;
            end else begin
               due = expected_conversions.pop_front();
               if ($signed(rsp_tdata) != due.converted) begin
                  $error("converted_ns: expected %0d, got %0d",
                         due.converted, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser[0] != due.pre) begin
                  $error("pre_table: expected %0d, got %0d", due.pre, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct[active_phase]);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus: directed edges first, then random requests in four idling phases.
   initial begin
      utlsc_pkg::func_type f;

      // UTC to TAI: extremes, zero, the drift era edge and the last two intervals
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, T_MIN, 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, T_MAX, 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, 0, 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, -1, 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI,
                  threshold_ns(utlsc_pkg::FUNC_UTC_TO_TAI, 0) - 1, 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, threshold_ns(utlsc_pkg::FUNC_UTC_TO_TAI, 0), 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, threshold_ns(utlsc_pkg::FUNC_UTC_TO_TAI, 22), 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI,
                  threshold_ns(utlsc_pkg::FUNC_UTC_TO_TAI, 23) - 1, 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI, threshold_ns(utlsc_pkg::FUNC_UTC_TO_TAI, 23), 0);
      add_request(utlsc_pkg::FUNC_UTC_TO_TAI,
                  threshold_ns(utlsc_pkg::FUNC_UTC_TO_TAI, 23) + 64'sd1000000000000000, 0);

      // TAI to UTC: saturation at both ends, the shifted thresholds and the window
      // between a leap date and its shifted threshold
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, T_MIN, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, T_MIN + DRIFT_OFFSET - 1, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, T_MIN + DRIFT_OFFSET, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, T_MAX, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, T_MAX - 33 * NS_SEC, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, T_MAX - 33 * NS_SEC + 1, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, 0, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, -1, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC,
                  threshold_ns(utlsc_pkg::FUNC_TAI_TO_UTC, 0) - 1, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, threshold_ns(utlsc_pkg::FUNC_TAI_TO_UTC, 0), 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, longint'(leap_days[1]) * NS_DAY + 5 * NS_SEC, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, threshold_ns(utlsc_pkg::FUNC_TAI_TO_UTC, 22), 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC,
                  threshold_ns(utlsc_pkg::FUNC_TAI_TO_UTC, 23) - 1, 0);
      add_request(utlsc_pkg::FUNC_TAI_TO_UTC, threshold_ns(utlsc_pkg::FUNC_TAI_TO_UTC, 23), 0);

      for (int p = 0; p < PHASES; p++) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            f = utlsc_pkg::func_type'($urandom_range(0, 1));
            add_request(f, random_time(f), p);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || expected_conversions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
